/* sv/hbe_pkg.sv */
// ----------------------------------------------------------------------------
// hbe_pkg
// Word types, codes and fixed widths of the harmonic bond energy and
// gradient unit.
// ----------------------------------------------------------------------------
`default_nettype none

package hbe_pkg;

  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_BOND    = 2'd1;
  localparam logic [1:0] ACT_RD_GRAD = 2'd2;
  localparam logic [1:0] ACT_RD_EN   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_LEN = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

  localparam int MAG_W  = 33;
  localparam int SQ_W   = 66;
  localparam int PROD_W = 99;
  localparam int Q_W    = 60;

  localparam logic [62:0] E_MAX = '1;

  typedef struct packed {
    logic [1:0]         action;
    logic [11:0]        atom_a;
    logic [11:0]        atom_b;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [31:0]        rest_length;
    logic [31:0]        force_const;
  } in_word_t;

  typedef struct packed {
    logic [62:0]        energy;
    logic signed [63:0] grad_x;
    logic signed [63:0] grad_y;
    logic signed [63:0] grad_z;
    logic [1:0]         status;
  } out_word_t;

endpackage

`default_nettype wire

/* sv/harmonic_bond_energy_gradient_top.sv */
// ----------------------------------------------------------------------------
// harmonic_bond_energy_gradient_top
// Harmonic bond energy and gradient unit on atom position and gradient RAMs.
// ----------------------------------------------------------------------------
// One word is worked on at a time. After reset the gradient RAM is cleared,
// one atom per cycle, before the first word is taken. A bond goes through
// 2 position reads, squaring, square root, products on the shared 33x33
// multiplier and the three-lane divider, then a read-modify-write of each
// atom's gradient.
// A finished word waits in the output register while the next word is taken.
`default_nettype none

module harmonic_bond_energy_gradient_top #(
  parameter int MAX_ATOMS = 4096,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hbe_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output hbe_pkg::out_word_t out_word
);
  import hbe_pkg::*;

  localparam int AW    = $clog2(MAX_ATOMS);
  localparam int DEN_W = MAG_W + FRAC_BITS;
  localparam int ESH   = 2 * FRAC_BITS;

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_EXEC  = 5'd2;
  localparam logic [4:0] S_RDG   = 5'd3;
  localparam logic [4:0] S_PA    = 5'd4;
  localparam logic [4:0] S_PB    = 5'd5;
  localparam logic [4:0] S_SQ    = 5'd6;
  localparam logic [4:0] S_SQCHK = 5'd7;
  localparam logic [4:0] S_SQRT  = 5'd8;
  localparam logic [4:0] S_S     = 5'd9;
  localparam logic [4:0] S_MUL   = 5'd10;
  localparam logic [4:0] S_EN    = 5'd11;
  localparam logic [4:0] S_DIV   = 5'd12;
  localparam logic [4:0] S_GA    = 5'd13;
  localparam logic [4:0] S_GB    = 5'd14;
  localparam logic [4:0] S_DONE  = 5'd15;

  logic [4:0]  state_r, state_nxt;
  logic [AW-1:0] clr_r;
  logic [3:0]  cnt_r;
  in_word_t    in_r;
  out_word_t   res_r, out_r;
  logic        out_valid_r;

  logic [AW-1:0] a_addr, b_addr;
  logic          a_ok, b_ok;

  logic          pos_we;
  logic [AW-1:0] pos_raddr;
  logic [95:0]   pos_rd;
  logic [95:0]   pa_r;

  logic          gr_we;
  logic [AW-1:0] gr_waddr, gr_raddr;
  logic [191:0]  gr_wdata, gr_rd;

  logic [2:0][MAG_W-1:0]  mag_r;
  logic [2:0]             dneg_r;
  logic [SQ_W-1:0]        sq_r;
  logic [MAG_W-1:0]       d_r, s_r;
  logic                   s_neg_r;
  logic [MAG_W-1:0]       op_a, op_b;
  logic [SQ_W-1:0]        prod_r;
  logic [SQ_W-1:0]        s2_r, tks_r;
  logic [PROD_W-1:0]      e_r;
  logic [2:0][PROD_W-1:0] num_r;
  logic [62:0]            energy_r;
  logic                   sat_r;

  logic                 sqrt_start, sqrt_done;
  logic [MAG_W-1:0]     sqrt_root;
  logic                 div_start, div_done;
  logic [2:0][Q_W-1:0]  quo;

  logic [PROD_W-1:0]    e_sh;
  logic                 e_over;
  logic [62:0]          e_term;
  logic [63:0]          e_sum;

  logic [2:0][63:0]     g_old, g_new;
  logic [2:0]           g_sat;
  logic                 gsat_any;

  assign a_addr = AW'(in_r.atom_a);
  assign b_addr = AW'(in_r.atom_b);
  assign a_ok   = 32'(in_r.atom_a) < 32'(MAX_ATOMS);
  assign b_ok   = 32'(in_r.atom_b) < 32'(MAX_ATOMS);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  hbe_ram #(.WIDTH(96), .DEPTH(MAX_ATOMS)) u_pos_ram (
    .clk(clk), .we(pos_we), .waddr(a_addr),
    .wdata({in_r.coord_x, in_r.coord_y, in_r.coord_z}),
    .raddr(pos_raddr), .rdata(pos_rd)
  );

  hbe_ram #(.WIDTH(192), .DEPTH(MAX_ATOMS)) u_grad_ram (
    .clk(clk), .we(gr_we), .waddr(gr_waddr), .wdata(gr_wdata),
    .raddr(gr_raddr), .rdata(gr_rd)
  );

  hbe_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sqrt_start), .rad(sq_r),
    .done(sqrt_done), .root(sqrt_root)
  );

  hbe_div #(.DEN_W(DEN_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(num_r),
    .den(DEN_W'(d_r) << FRAC_BITS), .done(div_done), .quo(quo)
  );

  always_comb begin
    e_sh   = e_r >> ESH;
    e_over = |e_sh[PROD_W-1:63];
    e_term = e_over ? E_MAX : e_sh[62:0];
    e_sum  = {1'b0, energy_r} + {1'b0, e_term};
  end

  always_comb begin
    logic signed [60:0] t;
    logic signed [64:0] sum;
    g_old = {gr_rd[63:0], gr_rd[127:64], gr_rd[191:128]};
    for (int k = 0; k < 3; k++) begin
      t = $signed({1'b0, quo[k]});
      if (s_neg_r != dneg_r[k]) begin
        t = -t;
      end
      if (state_r == S_GB) begin
        t = -t;
      end
      sum = $signed({g_old[k][63], g_old[k]}) + 65'(t);
      g_sat[k] = sum[64] != sum[63];
      if (g_sat[k]) begin
        g_new[k] = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
        g_new[k] = sum[63:0];
      end
    end
    gsat_any = |g_sat;
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state_r == S_SQ && cnt_r < 4'd3) begin
      op_a = mag_r[cnt_r[1:0]];
      op_b = mag_r[cnt_r[1:0]];
    end else if (state_r == S_MUL) begin
      case (cnt_r)
        4'd0: begin op_a = s_r;                op_b = s_r;              end
        4'd1: begin op_a = {in_r.force_const, 1'b0}; op_b = s_r;        end
        4'd2: begin op_a = s2_r[32:0];         op_b = {1'b0, in_r.force_const}; end
        4'd3: begin op_a = s2_r[65:33];        op_b = {1'b0, in_r.force_const}; end
        4'd4: begin op_a = tks_r[32:0];        op_b = mag_r[0];         end
        4'd5: begin op_a = tks_r[65:33];       op_b = mag_r[0];         end
        4'd6: begin op_a = tks_r[32:0];        op_b = mag_r[1];         end
        4'd7: begin op_a = tks_r[65:33];       op_b = mag_r[1];         end
        4'd8: begin op_a = tks_r[32:0];        op_b = mag_r[2];         end
        4'd9: begin op_a = tks_r[65:33];       op_b = mag_r[2];         end
        default: begin op_a = '0;              op_b = '0;               end
      endcase
    end
  end

  always_comb begin
    state_nxt  = state_r;
    pos_we     = 1'b0;
    pos_raddr  = (state_r == S_PA) ? b_addr : a_addr;
    gr_we      = 1'b0;
    gr_waddr   = a_addr;
    gr_wdata   = '0;
    gr_raddr   = (state_r == S_GA) ? b_addr : a_addr;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        gr_we    = 1'b1;
        gr_waddr = clr_r;
        if (clr_r == AW'(MAX_ATOMS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (in_r.action)
          ACT_LOAD: begin
            pos_we    = a_ok;
            gr_we     = a_ok;
            state_nxt = S_DONE;
          end
          ACT_BOND: begin
            state_nxt = (a_ok && b_ok) ? S_PA : S_DONE;
          end
          ACT_RD_GRAD: begin
            state_nxt = a_ok ? S_RDG : S_DONE;
          end
          ACT_RD_EN: begin
            state_nxt = S_DONE;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_RDG:   state_nxt = S_DONE;
      S_PA:    state_nxt = S_PB;
      S_PB:    state_nxt = S_SQ;
      S_SQ: begin
        if (cnt_r == 4'd3) begin
          state_nxt = S_SQCHK;
        end
      end
      S_SQCHK: begin
        if (sq_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          sqrt_start = 1'b1;
          state_nxt  = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sqrt_done) begin
          state_nxt = S_S;
        end
      end
      S_S:     state_nxt = S_MUL;
      S_MUL: begin
        if (cnt_r == 4'd10) begin
          state_nxt = S_EN;
        end
      end
      S_EN: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_GA;
        end
      end
      S_GA: begin
        gr_we     = 1'b1;
        gr_wdata  = {g_new[0], g_new[1], g_new[2]};
        state_nxt = S_GB;
      end
      S_GB: begin
        gr_we     = 1'b1;
        gr_waddr  = b_addr;
        gr_wdata  = {g_new[0], g_new[1], g_new[2]};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      energy_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_EXEC && in_r.action == ACT_RD_EN) begin
        energy_r <= '0;
      end else if (state_r == S_EN) begin
        energy_r <= e_sum[63] ? E_MAX : e_sum[62:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= SQ_W'(op_a * op_b);
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_r <= res_r;
    end
    unique case (state_r)
      S_IDLE: begin
        in_r  <= in_word;
        res_r <= '0;
      end
      S_EXEC: begin
        pa_r <= pos_rd;
        if (in_r.action == ACT_RD_EN) begin
          res_r.energy <= energy_r;
        end
      end
      S_RDG: begin
        res_r.grad_x <= gr_rd[191:128];
        res_r.grad_y <= gr_rd[127:64];
        res_r.grad_z <= gr_rd[63:0];
      end
      S_PA: begin
        pa_r <= pos_rd;
      end
      S_PB: begin
        for (int k = 0; k < 3; k++) begin
          logic [MAG_W-1:0] diff;
          diff = {pa_r[95-32*k], pa_r[95-32*k -: 32]}
               - {pos_rd[95-32*k], pos_rd[95-32*k -: 32]};
          dneg_r[k] <= diff[MAG_W-1];
          mag_r[k]  <= diff[MAG_W-1] ? MAG_W'(-diff) : diff;
        end
        sq_r  <= '0;
        cnt_r <= '0;
      end
      S_SQ: begin
        if (cnt_r != 4'd0) begin
          sq_r <= sq_r + prod_r;
        end
        cnt_r <= cnt_r + 1'b1;
      end
      S_SQCHK: begin
        sat_r <= 1'b0;
        if (sq_r == '0) begin
          res_r.status <= ST_ZERO_LEN;
        end
      end
      S_SQRT: begin
        d_r <= sqrt_root;
      end
      S_S: begin
        s_neg_r <= d_r < {1'b0, in_r.rest_length};
        s_r     <= (d_r < {1'b0, in_r.rest_length}) ?
                   {1'b0, in_r.rest_length} - d_r : d_r - {1'b0, in_r.rest_length};
        cnt_r   <= '0;
      end
      S_MUL: begin
        cnt_r <= cnt_r + 1'b1;
        case (cnt_r)
          4'd1:  s2_r     <= prod_r;
          4'd2:  tks_r    <= prod_r;
          4'd3:  e_r      <= PROD_W'(prod_r);
          4'd4:  e_r      <= e_r + (PROD_W'(prod_r) << MAG_W);
          4'd5:  num_r[0] <= PROD_W'(prod_r);
          4'd6:  num_r[0] <= num_r[0] + (PROD_W'(prod_r) << MAG_W);
          4'd7:  num_r[1] <= PROD_W'(prod_r);
          4'd8:  num_r[1] <= num_r[1] + (PROD_W'(prod_r) << MAG_W);
          4'd9:  num_r[2] <= PROD_W'(prod_r);
          4'd10: num_r[2] <= num_r[2] + (PROD_W'(prod_r) << MAG_W);
          default: begin
          end
        endcase
      end
      S_EN: begin
        sat_r <= e_over | e_sum[63];
      end
      S_GA: begin
        sat_r <= sat_r | gsat_any;
      end
      S_GB: begin
        res_r.status <= (sat_r | gsat_any) ? ST_SAT : ST_OK;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/hbe_ram.sv */
// ----------------------------------------------------------------------------
// hbe_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hbe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/hbe_sqrt.sv */
// ----------------------------------------------------------------------------
// hbe_sqrt
// Digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hbe_sqrt (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [hbe_pkg::SQ_W-1:0] rad,
  output logic                     done,
  output logic [hbe_pkg::MAG_W-1:0] root
);
  import hbe_pkg::*;

  localparam int RW    = MAG_W + 3;
  localparam int ITERS = SQ_W / 2;
  localparam int CW    = $clog2(ITERS);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [SQ_W-1:0] rad_r;
  logic [RW-1:0] rem_r;
  logic [RW-1:0] rem_sh;
  logic [RW-1:0] trial;
  logic          ge;

  always_comb begin
    rem_sh = {rem_r[RW-3:0], rad_r[SQ_W-1 -: 2]};
    trial  = RW'({root, 2'b01});
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rad_r  <= rad;
        rem_r  <= '0;
        root   <= '0;
      end else if (busy_r) begin
        rad_r <= rad_r << 2;
        rem_r <= ge ? rem_sh - trial : rem_sh;
        root  <= {root[MAG_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(ITERS - 1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* sv/hbe_div.sv */
// ----------------------------------------------------------------------------
// hbe_div
// Three-lane restoring divider sharing one denominator, one quotient bit
// per lane per cycle. Keeps the low quotient bits.
// ----------------------------------------------------------------------------
`default_nettype none

module hbe_div #(
  parameter int DEN_W = 49
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [2:0][hbe_pkg::PROD_W-1:0]  num,
  input  logic [DEN_W-1:0]                 den,
  output logic                             done,
  output logic [2:0][hbe_pkg::Q_W-1:0]     quo
);
  import hbe_pkg::*;

  localparam int CW = $clog2(PROD_W);

  logic                    busy_r;
  logic [CW-1:0]           cnt_r;
  logic [DEN_W-1:0]        den_r;
  logic [2:0][PROD_W-1:0]  num_r;
  logic [2:0][DEN_W-1:0]   rem_r;
  logic [2:0][DEN_W:0]     rem_sh;
  logic [2:0]              ge;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rem_sh[k] = {rem_r[k], num_r[k][PROD_W-1]};
      ge[k]     = rem_sh[k] >= {1'b0, den_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        den_r  <= den;
        num_r  <= num;
        rem_r  <= '0;
        quo    <= '0;
      end else if (busy_r) begin
        for (int k = 0; k < 3; k++) begin
          num_r[k] <= num_r[k] << 1;
          rem_r[k] <= ge[k] ? DEN_W'(rem_sh[k] - {1'b0, den_r}) : DEN_W'(rem_sh[k]);
          quo[k]   <= {quo[k][Q_W-2:0], ge[k]};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(PROD_W - 1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* sv/hbe_checker.sv */
// ----------------------------------------------------------------------------
// hbe_checker
// Port-level checks of the harmonic bond energy and gradient unit.
// ----------------------------------------------------------------------------
`default_nettype none

module hbe_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input hbe_pkg::out_word_t out_word
);
  import hbe_pkg::*;

  logic grad_nz;
  assign grad_nz = out_word.grad_x != '0 || out_word.grad_y != '0 ||
                   out_word.grad_z != '0;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word dropped or changed while stalled");

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a word is in work");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.status != 2'd3)
    else $error("undefined status code");

  a_energy_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.energy != '0 |-> !grad_nz && out_word.status == ST_OK)
    else $error("energy word carries gradient or status");

  a_grad_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && grad_nz |-> out_word.status == ST_OK)
    else $error("gradient word carries nonzero status");

endmodule

bind harmonic_bond_energy_gradient_top hbe_checker u_hbe_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
);

`default_nettype wire
